// File: hdl/servo_output_release_controller_assert.svh
// assertion macros for the servo output release controller
// expects clk and rst_n in the scope where a macro is used
`ifndef SERVO_OUTPUT_RELEASE_CONTROLLER_ASSERT_SVH
`define SERVO_OUTPUT_RELEASE_CONTROLLER_ASSERT_SVH

// same-cycle implication, off during reset
`define SORC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SORC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sorc_pkg.sv
// types and constants of the servo output release controller
// no dependencies
package sorc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ABS_MIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ABS_MAX      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_MIN       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_MAX       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIBRATED   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_POLICY = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_MS    = 3'd7;

    // reset values
    localparam logic [15:0] ABS_MIN_RESET   = 16'd500;
    localparam logic [15:0] ABS_MAX_RESET   = 16'd2500;
    localparam logic [15:0] OP_MIN_RESET    = 16'd1000;
    localparam logic [15:0] OP_MAX_RESET    = 16'd2000;
    localparam int          SETTLE_MS_RESET = 500;

    localparam int PERMILLE_FULL = 1000;
    localparam int MS_TO_US      = 1000;
    localparam int SETTLE_US_W   = 26;

    // x / 1000 == ((x >> 3) * RECIP_125) >> RECIP_SHIFT for x below 2**26
    localparam logic [23:0] RECIP_125   = 24'd8589935;
    localparam int          RECIP_SHIFT = 30;

    localparam logic [1:0] POLICY_RELEASE = 2'd1;

    typedef enum logic [2:0] {
        OP_MOVE_PULSE    = 3'd0,
        OP_MOVE_PERMILLE = 3'd1,
        OP_ENABLE        = 3'd2,
        OP_HOLD          = 3'd3,
        OP_DISABLE       = 3'd4,
        OP_TICK          = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ZONE_CLOSED = 2'd0,
        ZONE_OPEN   = 2'd1,
        ZONE_MID    = 2'd2
    } zone_t;

    typedef struct packed {
        logic [15:0] pulse_us;
        logic [15:0] command_us;
        logic        drive_on;
        logic        is_released;
        logic        released_now;
        logic        output_changed;
        zone_t       zone;
    } result_t;

endpackage

// File: hdl/servo_output_release_controller.sv
// servo output release controller: command pipeline, drive state and release timer
// depends on sorc_pkg and servo_output_release_controller_assert.svh
//
//  channel  | dir | handshake          | beat contents
//  ---------+-----+--------------------+-------------------------------------------
//  s        | in  | s_tvalid/s_tready  | s_tuser: op; s_tdata: value, now_us
//  m        | out | m_tvalid/m_tready  | m_tdata: pulse, command, flags, zone
//  cfg      | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// three register stages: product of span and position, scaled and clamped pulse,
// then drive state update with the result register; m_tvalid rises once the beat
// has passed all three, and one beat is taken every cycle while m is not stalled
// the drive state is updated in the last stage, so back-to-back items see each other
// a stall on m holds every stage that is full; empty stages still fill
// reset clears valid flags and drive state and loads the configuration reset values
`include "servo_output_release_controller_assert.svh"

module servo_output_release_controller
    import sorc_pkg::*;
#(
    parameter int SETTLE_FLOOR_MS = 100
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // [15:0] value, [63:16] now_us
    input  logic [2:0]             s_tuser,   // [2:0] op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] pulse_us, [31:16] command_us, [32] drive_on, [33] is_released,
    // [34] released_now, [35] output_changed, [37:36] zone, [39:38] zero
    output logic [39:0]            m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [15:0] SETTLE_FLOOR = 16'(SETTLE_FLOOR_MS);
    localparam logic [SETTLE_US_W-1:0] SETTLE_US_RESET = SETTLE_US_W'(
        (SETTLE_MS_RESET > SETTLE_FLOOR_MS ? SETTLE_MS_RESET : SETTLE_FLOOR_MS) * MS_TO_US);

    // configuration
    logic [15:0]            abs_min_reg, abs_max_reg, op_min_reg, op_max_reg;
    logic                   invert_reg, calibrated_reg;
    logic [5:0]             drive_policy_reg;
    logic [SETTLE_US_W-1:0] settle_us_reg, settle_us_next;
    logic [15:0]            settle_eff;

    // drive state
    logic [15:0] last_pulse_reg, last_pulse_next;
    logic [47:0] lct_reg, lct_next;
    logic        driven_reg, driven_next;
    logic        released_reg, released_next;
    logic        hold_reg, hold_next;

    // stage 1
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [15:0] s1_value_reg;
    logic [47:0] s1_now_reg;
    logic [25:0] s1_prod_reg, s1_prod_next;
    logic [9:0]  p_cap, p_dir;
    logic [15:0] span;

    // stage 2
    logic        s2_valid_reg;
    op_t         s2_op_reg;
    logic [47:0] s2_now_reg;
    logic [15:0] s2_pulse_reg, s2_pulse_next;
    logic [15:0] s2_command_reg, s2_command_next;
    logic [46:0] quot_prod;
    logic [15:0] raw_pulse;

    // output stage
    logic        m_valid_reg;
    result_t     out_reg, out_next;

    logic        out_ready, s2_ready, s1_ready, fire3;
    logic        changed, rel_now, settled;
    logic [48:0] elapsed;
    zone_t       zone_cur;
    logic [1:0]  code_cur;

    function automatic zone_t zone_of(input logic [15:0] v, input logic [15:0] lo,
                                      input logic [15:0] hi, input logic inv,
                                      input logic cal);
        logic signed [16:0] c, o, vs, d, e;
        logic signed [23:0] e50, d1, d49;
        logic               low, high;
        zone_t              z;
        c   = inv ? {1'b0, hi} : {1'b0, lo};
        o   = inv ? {1'b0, lo} : {1'b0, hi};
        vs  = {1'b0, v};
        d   = o - c;
        e   = vs - c;
        e50 = 24'(e) * 24'sd50;
        d1  = 24'(d);
        d49 = d1 * 24'sd49;
        if (d > 17'sd0)
        begin
            low  = e50 <= d1;
            high = e50 >= d49;
        end
        else
        begin
            low  = e50 >= d1;
            high = e50 <= d49;
        end
        if (!cal || lo == hi)
            z = ZONE_MID;
        else if (low)
            z = ZONE_CLOSED;
        else if (high)
            z = ZONE_OPEN;
        else
            z = ZONE_MID;
        return z;
    endfunction

    // handshake chain
    assign out_ready = !m_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign fire3     = out_ready && s2_valid_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, out_reg.zone, out_reg.output_changed, out_reg.released_now,
                        out_reg.is_released, out_reg.drive_on, out_reg.command_us,
                        out_reg.pulse_us};

    // configuration writes
    assign settle_eff     = (cfg_data < SETTLE_FLOOR) ? SETTLE_FLOOR : cfg_data;
    assign settle_us_next = SETTLE_US_W'(settle_eff) * SETTLE_US_W'(MS_TO_US);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_min_reg      <= ABS_MIN_RESET;
            abs_max_reg      <= ABS_MAX_RESET;
            op_min_reg       <= OP_MIN_RESET;
            op_max_reg       <= OP_MAX_RESET;
            invert_reg       <= 1'b0;
            calibrated_reg   <= 1'b0;
            drive_policy_reg <= '0;
            settle_us_reg    <= SETTLE_US_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ABS_MIN:      abs_min_reg      <= cfg_data;
                CFG_ABS_MAX:      abs_max_reg      <= cfg_data;
                CFG_OP_MIN:       op_min_reg       <= cfg_data;
                CFG_OP_MAX:       op_max_reg       <= cfg_data;
                CFG_INVERT:       invert_reg       <= cfg_data[0];
                CFG_CALIBRATED:   calibrated_reg   <= cfg_data[0];
                CFG_DRIVE_POLICY: drive_policy_reg <= cfg_data[5:0];
                CFG_SETTLE_MS:    settle_us_reg    <= settle_us_next;
                default:          ;
            endcase
        end
    end

    // stage 1: capped, mirrored position times span
    always_comb
    begin
        p_cap        = (s_tdata[15:0] > 16'(PERMILLE_FULL)) ? 10'(PERMILLE_FULL)
                                                            : s_tdata[9:0];
        p_dir        = invert_reg ? 10'(PERMILLE_FULL) - p_cap : p_cap;
        span         = (op_max_reg > op_min_reg) ? op_max_reg - op_min_reg : 16'd0;
        s1_prod_next = 26'(span) * 26'(p_dir);
    end

    // stage 2: divide by 1000, offset, clamp to absolute limits
    always_comb
    begin
        quot_prod       = 47'(s1_prod_reg[25:3]) * 47'(RECIP_125);
        s2_command_next = (s1_op_reg == OP_MOVE_PERMILLE)
                        ? op_min_reg + quot_prod[RECIP_SHIFT +: 16] : 16'd0;
        raw_pulse       = (s1_op_reg == OP_MOVE_PULSE) ? s1_value_reg : s2_command_next;
        if (raw_pulse < abs_min_reg)
            s2_pulse_next = abs_min_reg;
        else if (raw_pulse > abs_max_reg)
            s2_pulse_next = abs_max_reg;
        else
            s2_pulse_next = raw_pulse;
    end

    // stage 3: drive state
    always_comb
    begin
        zone_cur = zone_of(last_pulse_reg, op_min_reg, op_max_reg, invert_reg,
                           calibrated_reg);
        case (zone_cur)
            ZONE_CLOSED: code_cur = drive_policy_reg[1:0];
            ZONE_OPEN:   code_cur = drive_policy_reg[3:2];
            default:     code_cur = drive_policy_reg[5:4];
        endcase
        // negative elapsed time counts as not settled
        elapsed = {1'b0, s2_now_reg} - {1'b0, lct_reg};
        settled = !elapsed[48] && (elapsed[47:0] >= 48'(settle_us_reg));

        last_pulse_next = last_pulse_reg;
        lct_next        = lct_reg;
        driven_next     = driven_reg;
        released_next   = released_reg;
        hold_next       = hold_reg;
        changed         = 1'b0;
        rel_now         = 1'b0;

        case (s2_op_reg)
            OP_MOVE_PULSE, OP_MOVE_PERMILLE:
            begin
                last_pulse_next = s2_pulse_reg;
                lct_next        = s2_now_reg;
                hold_next       = 1'b0;
                changed         = !driven_reg;
                driven_next     = 1'b1;
                released_next   = 1'b0;
            end
            OP_ENABLE, OP_HOLD:
            begin
                lct_next      = s2_now_reg;
                changed       = !driven_reg;
                driven_next   = 1'b1;
                released_next = 1'b0;
                if (s2_op_reg == OP_HOLD)
                    hold_next = 1'b1;
            end
            OP_DISABLE:
            begin
                changed       = driven_reg || released_reg;
                driven_next   = 1'b0;
                released_next = 1'b0;
                hold_next     = 1'b0;
            end
            OP_TICK:
            begin
                if (driven_reg && !hold_reg && code_cur == POLICY_RELEASE && settled)
                begin
                    driven_next   = 1'b0;
                    released_next = 1'b1;
                    changed       = 1'b1;
                    rel_now       = 1'b1;
                end
            end
            default: ;
        endcase

        out_next.pulse_us       = last_pulse_next;
        out_next.command_us     = s2_command_reg;
        out_next.drive_on       = driven_next;
        out_next.is_released    = released_next;
        out_next.released_now   = rel_now;
        out_next.output_changed = changed;
        out_next.zone           = zone_of(last_pulse_next, op_min_reg, op_max_reg,
                                          invert_reg, calibrated_reg);
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_pulse_reg <= '0;
            lct_reg        <= '0;
            driven_reg     <= 1'b0;
            released_reg   <= 1'b0;
            hold_reg       <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                m_valid_reg <= s2_valid_reg;
            if (fire3)
            begin
                last_pulse_reg <= last_pulse_next;
                lct_reg        <= lct_next;
                driven_reg     <= driven_next;
                released_reg   <= released_next;
                hold_reg       <= hold_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s1_ready)
        begin
            s1_op_reg    <= op_t'(s_tuser);
            s1_value_reg <= s_tdata[15:0];
            s1_now_reg   <= s_tdata[63:16];
            s1_prod_reg  <= s1_prod_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_op_reg      <= s1_op_reg;
            s2_now_reg     <= s1_now_reg;
            s2_pulse_reg   <= s2_pulse_next;
            s2_command_reg <= s2_command_next;
        end
        if (fire3)
            out_reg <= out_next;
    end

    `SORC_ASSERT_NOW(a_release_excl, released_reg, !driven_reg, "released while driven")
    `SORC_ASSERT_NOW(a_hold_driven, hold_reg, driven_reg, "hold set without drive")
    `SORC_ASSERT_NOW(a_rel_now_flags, m_valid_reg && out_reg.released_now,
        out_reg.is_released && !out_reg.drive_on && out_reg.output_changed,
        "release beat with inconsistent flags")
    `SORC_ASSERT_NEXT(a_stall_state, m_valid_reg && !m_tready && s2_valid_reg,
        $stable(driven_reg) && $stable(last_pulse_reg), "state moved during stall")

endmodule

// File: dv/tb_servo_output_release_controller.sv
// testbench for servo_output_release_controller: directed and random command streams
// checked beat by beat against a behavioral predictor; needs only sorc_pkg and the rtl
`timescale 1ns / 100ps

module tb_servo_output_release_controller;
    import sorc_pkg::*;

    localparam int          SETTLE_FLOOR_MS = 100;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          PHASE_ITEMS     = 238;
    localparam logic [2:0]  OP_SPARE_6      = 3'd6;
    localparam logic [2:0]  OP_SPARE_7      = 3'd7;
    localparam logic [5:0]  POLICY_ALL_REL  = 6'b010101;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // [15:0] value, [63:16] now_us
    logic [2:0]             s_tuser;   // [2:0] op
    logic                   m_tvalid;
    logic                   m_tready;
    // [15:0] pulse_us, [31:16] command_us, [32] drive_on, [33] is_released,
    // [34] released_now, [35] output_changed, [37:36] zone, [39:38] zero
    logic [39:0]            m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers and drive state
    logic [15:0] reg_abs_min, reg_abs_max, reg_op_min, reg_op_max, reg_settle_ms;
    logic        reg_invert, reg_calibrated;
    logic [5:0]  reg_policy;
    logic [15:0] cur_pulse;
    logic [47:0] cmd_stamp_us;
    logic        is_driven, is_rel, hold_for_move, drive_change;

    result_t     pending_results[$];
    int          mismatches;
    int          quiet_cycles;
    bit          src_idle_en;
    bit          sink_idle_en;
    int          sink_stall;
    logic [47:0] clock_us;

    servo_output_release_controller #(
        .SETTLE_FLOOR_MS(SETTLE_FLOOR_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 25);
    endfunction

    function automatic int unsigned settle_span_us();
        int unsigned ms;
        ms = reg_settle_ms;
        if (ms < SETTLE_FLOOR_MS)
            ms = SETTLE_FLOOR_MS;
        return ms * MS_TO_US;
    endfunction

    function automatic zone_t pulse_zone(logic [15:0] pulse);
        longint closed_end, open_end, span, offs;
        logic   near_closed, near_open;
        if (!reg_calibrated || reg_op_min == reg_op_max)
            return ZONE_MID;
        closed_end = reg_invert ? reg_op_max : reg_op_min;
        open_end   = reg_invert ? reg_op_min : reg_op_max;
        span       = open_end - closed_end;
        offs       = pulse;
        offs       = offs - closed_end;
        // cross-multiplied 1/50 and 49/50 tests, sense flips on a negative span
        if (span > 0)
        begin
            near_closed = (50 * offs <= span);
            near_open   = (50 * offs >= 49 * span);
        end
        else
        begin
            near_closed = (50 * offs >= span);
            near_open   = (50 * offs <= 49 * span);
        end
        if (near_closed)
            return ZONE_CLOSED;
        if (near_open)
            return ZONE_OPEN;
        return ZONE_MID;
    endfunction

    function automatic void apply_move(logic [15:0] target, logic [47:0] now_us);
        if (target < reg_abs_min)
            cur_pulse = reg_abs_min;
        else if (target > reg_abs_max)
            cur_pulse = reg_abs_max;
        else
            cur_pulse = target;
        cmd_stamp_us  = now_us;
        hold_for_move = 1'b0;
        if (!is_driven)
            drive_change = 1'b1;
        is_driven = 1'b1;
        is_rel    = 1'b0;
    endfunction

    function automatic void apply_enable(logic [47:0] now_us);
        is_rel       = 1'b0;
        cmd_stamp_us = now_us;
        if (!is_driven)
            drive_change = 1'b1;
        is_driven = 1'b1;
    endfunction

    function automatic logic try_release(logic [47:0] now_us);
        int     z;
        longint elapsed, stamp;
        if (!is_driven || hold_for_move)
            return 1'b0;
        z = pulse_zone(cur_pulse);
        if (reg_policy[2*z +: 2] != POLICY_RELEASE)
            return 1'b0;
        elapsed = now_us;
        stamp   = cmd_stamp_us;
        // time running backwards never counts as settled
        if (elapsed - stamp < longint'(settle_span_us()))
            return 1'b0;
        is_driven    = 1'b0;
        is_rel       = 1'b1;
        drive_change = 1'b1;
        return 1'b1;
    endfunction

    function automatic result_t predict_servo(logic [2:0] op, logic [15:0] value,
                                              logic [47:0] now_us);
        result_t     res;
        int          pos, lo, hi, span;
        logic [15:0] scaled;
        logic        rel_now;
        scaled  = '0;
        rel_now = 1'b0;
        case (op)
            OP_MOVE_PULSE:
                apply_move(value, now_us);
            OP_MOVE_PERMILLE:
            begin
                pos = (value > PERMILLE_FULL) ? PERMILLE_FULL : value;
                if (reg_invert)
                    pos = PERMILLE_FULL - pos;
                lo     = reg_op_min;
                hi     = reg_op_max;
                span   = (hi > lo) ? hi - lo : 0;
                scaled = 16'(lo + (span * pos) / PERMILLE_FULL);
                apply_move(scaled, now_us);
            end
            OP_ENABLE:
                apply_enable(now_us);
            OP_HOLD:
            begin
                apply_enable(now_us);
                hold_for_move = 1'b1;
            end
            OP_DISABLE:
            begin
                if (is_driven || is_rel)
                    drive_change = 1'b1;
                is_driven     = 1'b0;
                is_rel        = 1'b0;
                hold_for_move = 1'b0;
            end
            OP_TICK:
                rel_now = try_release(now_us);
            default:
                ;
        endcase
        res.pulse_us       = cur_pulse;
        res.command_us     = scaled;
        res.drive_on       = is_driven;
        res.is_released    = is_rel;
        res.released_now   = rel_now;
        res.output_changed = drive_change;
        res.zone           = pulse_zone(cur_pulse);
        drive_change       = 1'b0;
        return res;
    endfunction

    function automatic void apply_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ABS_MIN:      reg_abs_min    = data;
            CFG_ABS_MAX:      reg_abs_max    = data;
            CFG_OP_MIN:       reg_op_min     = data;
            CFG_OP_MAX:       reg_op_max     = data;
            CFG_INVERT:       reg_invert     = data[0];
            CFG_CALIBRATED:   reg_calibrated = data[0];
            CFG_DRIVE_POLICY: reg_policy     = data[5:0];
            CFG_SETTLE_MS:    reg_settle_ms  = data;
            default:          ;
        endcase
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // predicts on input beats, checks output beats
    always @(posedge clk)
    begin : beat_check
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                apply_cfg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_servo(s_tuser, s_tdata[15:0],
                                                        s_tdata[63:16]));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no result pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("pulse_us", want.pulse_us, m_tdata[15:0]);
                    check_field("command_us", want.command_us, m_tdata[31:16]);
                    check_field("drive_on", want.drive_on, m_tdata[32]);
                    check_field("is_released", want.is_released, m_tdata[33]);
                    check_field("released_now", want.released_now, m_tdata[34]);
                    check_field("output_changed", want.output_changed, m_tdata[35]);
                    check_field("zone", want.zone, m_tdata[37:36]);
                    check_field("pad", 0, m_tdata[39:38]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 3) == 0)
        begin
            sink_stall <= pick_gap() - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_item(logic [2:0] op, logic [15:0] value, logic [47:0] now_us);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now_us, value};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_ranges(logic [15:0] amin, logic [15:0] amax,
                                logic [15:0] omin, logic [15:0] omax);
        write_cfg(CFG_ABS_MIN, amin);
        write_cfg(CFG_ABS_MAX, amax);
        write_cfg(CFG_OP_MIN, omin);
        write_cfg(CFG_OP_MAX, omax);
    endtask

    // reset configuration: uncalibrated, so every pulse sits in the middle zone
    task automatic test_reset_config();
        send_item(OP_TICK, 16'hFFFF, 48'd0);
        send_item(OP_MOVE_PULSE, 16'd0, 48'd10);
        send_item(OP_MOVE_PULSE, 16'hFFFF, 48'd20);
        send_item(OP_MOVE_PERMILLE, 16'hFFFF, 48'd30);
        send_item(OP_MOVE_PERMILLE, 16'd0, 48'd40);
        send_item(OP_DISABLE, 16'h5A5A, 48'd50);
        send_item(OP_ENABLE, 16'h0000, 48'd60);
        send_item(OP_SPARE_6, 16'hA5A5, 48'hFFFF_FFFF_FFFF);
        send_item(OP_SPARE_7, 16'h5A5A, 48'h5555_5555_5555);
    endtask

    task automatic test_zone_bounds();
        wait_drained();
        write_cfg(CFG_CALIBRATED, 16'd1);
        write_cfg(CFG_DRIVE_POLICY, {10'd0, POLICY_ALL_REL});
        // exact 1/50 and 49/50 boundaries of a 1000 us span
        send_item(OP_MOVE_PULSE, 16'd1020, 48'd1000);
        send_item(OP_MOVE_PULSE, 16'd1021, 48'd1010);
        send_item(OP_MOVE_PULSE, 16'd1980, 48'd1020);
        send_item(OP_MOVE_PULSE, 16'd1979, 48'd1030);
        wait_drained();
        write_cfg(CFG_INVERT, 16'd1);
        send_item(OP_MOVE_PERMILLE, 16'd0, 48'd1040);
        wait_drained();
        // reversed working range: scaling span is zero
        write_cfg(CFG_INVERT, 16'd0);
        write_ranges(16'd500, 16'd2500, 16'd2000, 16'd1000);
        send_item(OP_MOVE_PERMILLE, 16'd500, 48'd1050);
        wait_drained();
        // reversed absolute limits
        write_ranges(16'd3000, 16'd1000, 16'd1000, 16'd2000);
        send_item(OP_MOVE_PULSE, 16'd2000, 48'd1060);
        send_item(OP_MOVE_PULSE, 16'd3500, 48'd1070);
    endtask

    task automatic test_release_timing();
        wait_drained();
        write_ranges(ABS_MIN_RESET, ABS_MAX_RESET, OP_MIN_RESET, OP_MAX_RESET);
        write_cfg(CFG_SETTLE_MS, 16'd0);
        send_item(OP_MOVE_PULSE, 16'd1000, 48'd1_000_000);
        send_item(OP_TICK, 16'd0, 48'd1_099_999);
        send_item(OP_TICK, 16'd0, 48'd1_100_000);
        send_item(OP_HOLD, 16'd0, 48'd1_400_000);
        send_item(OP_ENABLE, 16'd0, 48'd1_410_000);
        // enable keeps the hold, so no release here
        send_item(OP_TICK, 16'd0, 48'd1_900_000);
        send_item(OP_MOVE_PULSE, 16'd1500, 48'd2_000_000);
        send_item(OP_TICK, 16'd0, 48'd1_500_000);
        send_item(OP_DISABLE, 16'd0, 48'd2_100_000);
        send_item(OP_TICK, 16'd0, 48'hFFFF_FFFF_FFFF);
    endtask

    task automatic load_random_config(int mode);
        logic [15:0] junk, amin, amax, omin, omax, settle;
        logic [5:0]  policy;
        logic        inv, cal;
        int          r;
        junk = 16'($urandom);
        if (mode == 0)
        begin
            amin = '0; amax = '0; omin = '0; omax = '0; settle = '0;
            policy = '0; inv = 1'b0; cal = 1'b0;
        end
        else if (mode == 1)
        begin
            amin = '1; amax = '1; omin = '1; omax = '1; settle = '1;
            policy = '1; inv = 1'b1; cal = 1'b1;
        end
        else
        begin
            r    = $urandom_range(0, 99);
            amin = (r < 80) ? 16'($urandom_range(300, 900)) : 16'($urandom);
            r    = $urandom_range(0, 99);
            amax = (r < 80) ? 16'($urandom_range(2100, 2800)) : 16'($urandom);
            r    = $urandom_range(0, 99);
            if (r < 75)
            begin
                omin = 16'($urandom_range(800, 1400));
                omax = 16'($urandom_range(1600, 2200));
            end
            else if (r < 85)
            begin
                omin = 16'($urandom_range(800, 2200));
                omax = omin;
            end
            else
            begin
                omin = 16'($urandom);
                omax = 16'($urandom);
            end
            inv = 1'($urandom_range(0, 1));
            cal = ($urandom_range(0, 99) < 85);
            for (int z = 0; z < 3; z++)
                policy[2*z +: 2] = ($urandom_range(0, 99) < 65) ? POLICY_RELEASE
                                                                : 2'($urandom_range(0, 3));
            r      = $urandom_range(0, 99);
            settle = (r < 70) ? 16'($urandom_range(0, 400)) :
                     (r < 85) ? 16'($urandom_range(0, 99)) : 16'($urandom);
        end
        write_ranges(amin, amax, omin, omax);
        // spare data bits ride along on the single-bit registers and the policy register
        write_cfg(CFG_INVERT, {junk[15:1], inv});
        write_cfg(CFG_CALIBRATED, {junk[14:0], cal});
        write_cfg(CFG_DRIVE_POLICY, {junk[9:0], policy});
        write_cfg(CFG_SETTLE_MS, settle);
    endtask

    task automatic send_random_item();
        logic [2:0]  op;
        logic [15:0] value;
        logic [47:0] now_us;
        int          r;
        int unsigned settle_us;
        r = $urandom_range(0, 99);
        op = (r < 18) ? OP_MOVE_PULSE :
             (r < 36) ? OP_MOVE_PERMILLE :
             (r < 44) ? OP_ENABLE :
             (r < 50) ? OP_HOLD :
             (r < 56) ? OP_DISABLE :
             (r < 97) ? OP_TICK :
             (r < 99) ? OP_SPARE_6 : OP_SPARE_7;
        r = $urandom_range(0, 99);
        if (op == OP_MOVE_PULSE)
            value = (r < 70) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
        else if (op == OP_MOVE_PERMILLE)
            value = (r < 75) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
        else
            value = 16'($urandom);
        settle_us = settle_span_us();
        r = $urandom_range(0, 99);
        if (r < 2)
            now_us = 48'({$urandom, $urandom});
        else if (r < 5)
            now_us = clock_us - $urandom_range(1, 200_000);
        else if (op == OP_TICK)
            now_us = ($urandom_range(0, 1) == 1)
                     ? clock_us + $urandom_range(0, settle_us / 4)
                     : clock_us + $urandom_range(settle_us / 2, settle_us * 2);
        else
            now_us = clock_us + $urandom_range(0, 2000);
        clock_us = now_us;
        send_item(op, value, now_us);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            load_random_config(phase);
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                send_random_item();
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_MOVE_PULSE;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ABS_MIN;
        cfg_data       = '0;
        mismatches     = 0;
        quiet_cycles   = 0;
        sink_stall     = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        clock_us       = 48'd5_000_000;
        reg_abs_min    = ABS_MIN_RESET;
        reg_abs_max    = ABS_MAX_RESET;
        reg_op_min     = OP_MIN_RESET;
        reg_op_max     = OP_MAX_RESET;
        reg_invert     = 1'b0;
        reg_calibrated = 1'b0;
        reg_policy     = '0;
        reg_settle_ms  = SETTLE_MS_RESET;
        cur_pulse      = '0;
        cmd_stamp_us   = '0;
        is_driven      = 1'b0;
        is_rel         = 1'b0;
        hold_for_move  = 1'b0;
        drive_change   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_zone_bounds();
        test_release_timing();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: servo_output_release_controller.f
+incdir+hdl
hdl/sorc_pkg.sv
hdl/servo_output_release_controller.sv
dv/tb_servo_output_release_controller.sv
